// File: rtl/core/tapf_pkg.sv
package tapf_pkg;

	localparam int unsigned QW    = 16;
	localparam int unsigned REM_W = 33;
	localparam int unsigned DIV_W = 17;
	localparam int unsigned QUO_W = 16;

	localparam logic [QW-1:0] SPACING_RESET = 16'd2560;

endpackage

// File: rtl/core/tapf_div_cell.sv
module tapf_div_cell #(
	parameter int unsigned K   = 0,
	parameter int unsigned SBW = 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            v_i,
	input  logic [tapf_pkg::REM_W-1:0]      rem_i,
	input  logic [tapf_pkg::QUO_W-1:0]      q_i,
	input  logic [tapf_pkg::DIV_W-1:0]      d_i,
	input  logic [SBW-1:0]                  sb_i,
	output logic                            v_o,
	output logic [tapf_pkg::REM_W-1:0]      rem_o,
	output logic [tapf_pkg::QUO_W-1:0]      q_o,
	output logic [tapf_pkg::DIV_W-1:0]      d_o,
	output logic [SBW-1:0]                  sb_o
);

	logic [tapf_pkg::REM_W-1:0] trial;
	logic                       ge;

	assign trial = tapf_pkg::REM_W'(d_i) << K;
	assign ge    = rem_i >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_o <= 1'b0;
		end else if (en) begin
			v_o <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o <= ge ? rem_i - trial : rem_i;
			q_o   <= q_i | (tapf_pkg::QUO_W'(ge) << K);
			d_o   <= d_i;
			sb_o  <= sb_i;
		end
	end

endmodule

// File: rtl/core/tapf_sqrt_cell.sv
module tapf_sqrt_cell #(
	parameter int unsigned RW  = 16,
	parameter int unsigned SBW = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              v_i,
	input  logic [2*RW-1:0]   rad_i,
	input  logic [RW+1:0]     rem_i,
	input  logic [RW-1:0]     root_i,
	input  logic [SBW-1:0]    sb_i,
	output logic              v_o,
	output logic [2*RW-1:0]   rad_o,
	output logic [RW+1:0]     rem_o,
	output logic [RW-1:0]     root_o,
	output logic [SBW-1:0]    sb_o
);

	logic [RW+3:0] remn;
	logic [RW+3:0] trial;
	logic [RW+3:0] diff;
	logic          ge;

	assign remn  = {rem_i, rad_i[2*RW-1 -: 2]};
	assign trial = {2'b00, root_i, 2'b01};
	assign ge    = remn >= trial;
	assign diff  = remn - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_o <= 1'b0;
		end else if (en) begin
			v_o <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_o  <= rad_i << 2;
			rem_o  <= ge ? diff[RW+1:0] : remn[RW+1:0];
			root_o <= {root_i[RW-2:0], ge};
			sb_o   <= sb_i;
		end
	end

endmodule

// File: rtl/core/tapf_sqrt_chain.sv
module tapf_sqrt_chain #(
	parameter int unsigned RW  = 16,
	parameter int unsigned SBW = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              v_i,
	input  logic [2*RW-1:0]   rad_i,
	input  logic [SBW-1:0]    sb_i,
	output logic              v_o,
	output logic [RW-1:0]     root_o,
	output logic [SBW-1:0]    sb_o
);

	logic              v    [0:RW];
	logic [2*RW-1:0]   rad  [0:RW];
	logic [RW+1:0]     rem  [0:RW];
	logic [RW-1:0]     root [0:RW];
	logic [SBW-1:0]    sb   [0:RW];

	assign v[0]    = v_i;
	assign rad[0]  = rad_i;
	assign rem[0]  = '0;
	assign root[0] = '0;
	assign sb[0]   = sb_i;

	for (genvar i = 0; i < RW; i++) begin : g_cell
		tapf_sqrt_cell #(.RW(RW), .SBW(SBW)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.v_i    (v[i]),
			.rad_i  (rad[i]),
			.rem_i  (rem[i]),
			.root_i (root[i]),
			.sb_i   (sb[i]),
			.v_o    (v[i+1]),
			.rad_o  (rad[i+1]),
			.rem_o  (rem[i+1]),
			.root_o (root[i+1]),
			.sb_o   (sb[i+1])
		);
	end

	assign v_o    = v[RW];
	assign root_o = root[RW];
	assign sb_o   = sb[RW];

	// remainder never exceeds eight times the root
	assert property (@(posedge clk) disable iff (!arst_n)
		v[RW] |-> ({2'b00, rad[RW][1:0] & 2'b00, rem[RW]} <= {2'b00, root[RW], 3'b000}))
		else $error("sqrt remainder out of range");

endmodule

// File: rtl/core/three_anchor_position_fix.sv
// Three-anchor 2-D position fix, Q8.8.
// Input channel (in_valid / in_stall): one word carries dist_a, dist_b,
// dist_c, ref_x and ref_y. Output channel (out_valid / out_stall): one
// word per input word with solved, pos_x, pos_y and ref_distance; the
// position fields are zero when solved is low.
// anchor_spacing is written through cfg_we / cfg_data and is 10.0 after
// reset; the user must write it only while idle (the block has no check).
// Throughput: one word per cycle unless out_stall holds the chain; the
// datapath is a chain of cells, one restoring-divide cell per quotient
// bit (16) and one square-root cell per root bit for the four roots
// (16, 17, 18, 18), plus multiply and add stages.
// Reset (arst_n low) clears every valid bit in the chain and out_valid
// and restores the spacing.
// While out_valid is high and out_stall is high the whole chain holds
// and in_stall is raised; nothing is dropped.
module three_anchor_position_fix (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [15:0]        dist_a,
	input  logic [15:0]        dist_b,
	input  logic [15:0]        dist_c,
	input  logic signed [15:0] ref_x,
	input  logic signed [15:0] ref_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               solved,
	output logic signed [16:0] pos_x,
	output logic signed [16:0] pos_y,
	output logic [17:0]        ref_distance
);

	typedef struct packed {
		logic               bad;
		logic               neg;
		logic [31:0]        asq;
		logic [15:0]        s;
		logic [15:0]        c;
		logic signed [15:0] rx;
		logic signed [15:0] ry;
	} div_sb_t;

	typedef struct packed {
		logic               bad;
		logic signed [16:0] x;
		logic [31:0]        xsq;
		logic [15:0]        s;
		logic [15:0]        c;
		logic signed [15:0] rx;
		logic signed [15:0] ry;
	} h_sb_t;

	typedef struct packed {
		logic               bad;
		logic signed [16:0] x;
		logic [15:0]        h;
		logic [34:0]        rdm;
		logic [15:0]        c;
		logic signed [15:0] rx;
		logic signed [15:0] ry;
	} dp_sb_t;

	typedef struct packed {
		logic               bad;
		logic signed [16:0] x;
		logic [15:0]        h;
		logic [16:0]        dp;
		logic [15:0]        c;
		logic signed [15:0] rx;
		logic signed [15:0] ry;
	} dm_sb_t;

	typedef struct packed {
		logic               bad;
		logic signed [16:0] x;
		logic signed [16:0] y;
	} r_sb_t;

	logic        en;
	logic [15:0] spacing_q;

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spacing_q <= tapf_pkg::SPACING_RESET;
		end else if (cfg_we) begin
			spacing_q <= cfg_data;
		end
	end

	// front: squares, numerator, feasibility
	logic               v_s1, v_s2, v_s3, v_s4;
	logic [15:0]        a_s1, b_s1, c_s1, s_s1;
	logic signed [15:0] rx_s1, ry_s1;
	logic [31:0]        asq_s2, bsq_s2, ssq_s2, sa_s2;
	logic               z_s2;
	logic [15:0]        s_s2, c_s2;
	logic signed [15:0] rx_s2, ry_s2;
	logic signed [33:0] num_s3;
	logic [32:0]        lim_s3;
	logic               z_s3;
	logic [31:0]        asq_s3;
	logic [15:0]        s_s3, c_s3;
	logic signed [15:0] rx_s3, ry_s3;
	logic [32:0]        absn_s4;
	div_sb_t            dsb_s4;

	logic signed [33:0] absn_full;
	assign absn_full = num_s3[33] ? -num_s3 : num_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= dist_a;
			b_s1  <= dist_b;
			c_s1  <= dist_c;
			rx_s1 <= ref_x;
			ry_s1 <= ref_y;
			s_s1  <= spacing_q;

			asq_s2 <= a_s1 * a_s1;
			bsq_s2 <= b_s1 * b_s1;
			ssq_s2 <= s_s1 * s_s1;
			sa_s2  <= s_s1 * a_s1;
			z_s2   <= (a_s1 == '0) || (s_s1 == '0);
			s_s2   <= s_s1;
			c_s2   <= c_s1;
			rx_s2  <= rx_s1;
			ry_s2  <= ry_s1;

			num_s3 <= $signed({2'b00, asq_s2}) + $signed({2'b00, ssq_s2})
				- $signed({2'b00, bsq_s2});
			lim_s3 <= {sa_s2, 1'b0};
			z_s3   <= z_s2;
			asq_s3 <= asq_s2;
			s_s3   <= s_s2;
			c_s3   <= c_s2;
			rx_s3  <= rx_s2;
			ry_s3  <= ry_s2;

			absn_s4    <= absn_full[32:0];
			dsb_s4.bad <= z_s3 || (absn_full[32:0] > lim_s3);
			dsb_s4.neg <= num_s3[33];
			dsb_s4.asq <= asq_s3;
			dsb_s4.s   <= s_s3;
			dsb_s4.c   <= c_s3;
			dsb_s4.rx  <= rx_s3;
			dsb_s4.ry  <= ry_s3;
		end
	end

	// divider chain, one quotient bit per cell
	localparam int unsigned NQ = tapf_pkg::QUO_W;
	localparam int unsigned DSBW = $bits(div_sb_t);

	logic                        dv   [0:NQ];
	logic [tapf_pkg::REM_W-1:0]  drem [0:NQ];
	logic [tapf_pkg::QUO_W-1:0]  dq   [0:NQ];
	logic [tapf_pkg::DIV_W-1:0]  dd   [0:NQ];
	logic [DSBW-1:0]             dsb  [0:NQ];

	assign dv[0]   = v_s4;
	assign drem[0] = absn_s4;
	assign dq[0]   = '0;
	assign dd[0]   = {dsb_s4.s, 1'b0};
	assign dsb[0]  = dsb_s4;

	for (genvar i = 0; i < NQ; i++) begin : g_div
		tapf_div_cell #(.K(NQ-1-i), .SBW(DSBW)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.v_i    (dv[i]),
			.rem_i  (drem[i]),
			.q_i    (dq[i]),
			.d_i    (dd[i]),
			.sb_i   (dsb[i]),
			.v_o    (dv[i+1]),
			.rem_o  (drem[i+1]),
			.q_o    (dq[i+1]),
			.d_o    (dd[i+1]),
			.sb_o   (dsb[i+1])
		);
	end

	div_sb_t dq_sb;
	assign dq_sb = div_sb_t'(dsb[NQ]);

	// X, X^2, radicand of h
	logic               v_s5, v_s6, v_s7;
	div_sb_t            sb_s5, sb_s6, sb_s7;
	logic signed [16:0] x_s5, x_s6, x_s7;
	logic [31:0]        xsq_s6, xsq_s7, rad_s7;
	logic signed [33:0] xsq_full;

	assign xsq_full = x_s5 * x_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s5 <= dv[NQ];
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s5   <= dq_sb.neg ? -$signed({1'b0, dq[NQ]}) : $signed({1'b0, dq[NQ]});
			sb_s5  <= dq_sb;
			x_s6   <= x_s5;
			xsq_s6 <= xsq_full[31:0];
			sb_s6  <= sb_s5;
			x_s7   <= x_s6;
			xsq_s7 <= xsq_s6;
			rad_s7 <= sb_s6.bad ? '0 : sb_s6.asq - xsq_s6;
			sb_s7  <= sb_s6;
		end
	end

	h_sb_t hsb_in, hsb_out;
	logic  hv;
	logic [15:0] h_root;

	assign hsb_in.bad = sb_s7.bad;
	assign hsb_in.x   = x_s7;
	assign hsb_in.xsq = xsq_s7;
	assign hsb_in.s   = sb_s7.s;
	assign hsb_in.c   = sb_s7.c;
	assign hsb_in.rx  = sb_s7.rx;
	assign hsb_in.ry  = sb_s7.ry;

	tapf_sqrt_chain #(.RW(16), .SBW($bits(h_sb_t))) u_h (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_i    (v_s7),
		.rad_i  (rad_s7),
		.sb_i   (hsb_in),
		.v_o    (hv),
		.root_o (h_root),
		.sb_o   (hsb_out)
	);

	// radicands of the two candidate distances to anchor C
	logic               v_s8, v_s9, v_s10;
	h_sb_t              hsb_s8, hsb_s9, hsb_s10;
	logic [15:0]        h_s8, h_s9, h_s10;
	logic signed [17:0] smh_s8;
	logic [16:0]        sph_s8;
	logic [31:0]        smsq_s9;
	logic [33:0]        spsq_s9;
	logic [32:0]        rdp_s10;
	logic [34:0]        rdm_s10;
	logic signed [35:0] smsq_full;
	logic [33:0]        spsq_full;

	assign smsq_full = smh_s8 * smh_s8;
	assign spsq_full = sph_s8 * sph_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s8  <= hv;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			smh_s8  <= $signed({2'b00, hsb_out.s}) - $signed({2'b00, h_root});
			sph_s8  <= {1'b0, hsb_out.s} + {1'b0, h_root};
			h_s8    <= h_root;
			hsb_s8  <= hsb_out;
			smsq_s9 <= smsq_full[31:0];
			spsq_s9 <= spsq_full;
			h_s9    <= h_s8;
			hsb_s9  <= hsb_s8;
			rdp_s10 <= {1'b0, hsb_s9.xsq} + {1'b0, smsq_s9};
			rdm_s10 <= {3'b000, hsb_s9.xsq} + {1'b0, spsq_s9};
			h_s10   <= h_s9;
			hsb_s10 <= hsb_s9;
		end
	end

	dp_sb_t dpsb_in, dpsb_out;
	logic   dpv;
	logic [16:0] dp_root;

	assign dpsb_in.bad = hsb_s10.bad;
	assign dpsb_in.x   = hsb_s10.x;
	assign dpsb_in.h   = h_s10;
	assign dpsb_in.rdm = rdm_s10;
	assign dpsb_in.c   = hsb_s10.c;
	assign dpsb_in.rx  = hsb_s10.rx;
	assign dpsb_in.ry  = hsb_s10.ry;

	tapf_sqrt_chain #(.RW(17), .SBW($bits(dp_sb_t))) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_i    (v_s10),
		.rad_i  ({1'b0, rdp_s10}),
		.sb_i   (dpsb_in),
		.v_o    (dpv),
		.root_o (dp_root),
		.sb_o   (dpsb_out)
	);

	dm_sb_t dmsb_in, dmsb_out;
	logic   dmv;
	logic [17:0] dm_root;

	assign dmsb_in.bad = dpsb_out.bad;
	assign dmsb_in.x   = dpsb_out.x;
	assign dmsb_in.h   = dpsb_out.h;
	assign dmsb_in.dp  = dp_root;
	assign dmsb_in.c   = dpsb_out.c;
	assign dmsb_in.rx  = dpsb_out.rx;
	assign dmsb_in.ry  = dpsb_out.ry;

	tapf_sqrt_chain #(.RW(18), .SBW($bits(dm_sb_t))) u_dm (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_i    (dpv),
		.rad_i  ({1'b0, dpsb_out.rdm}),
		.sb_i   (dmsb_in),
		.v_o    (dmv),
		.root_o (dm_root),
		.sb_o   (dmsb_out)
	);

	// sign choice, then squared distance to the reference point
	logic               v_s11, v_s12, v_s13, v_s14, v_s15;
	dm_sb_t             msb_s11;
	logic signed [18:0] dpc_s11, dmc_s11;
	logic               bad_s12, bad_s13, bad_s14, bad_s15;
	logic signed [16:0] x_s12, x_s13, x_s14, x_s15;
	logic signed [16:0] y_s12, y_s13, y_s14, y_s15;
	logic signed [15:0] rx_s12, ry_s12;
	logic signed [17:0] ex_s13, ey_s13;
	logic [33:0]        exsq_s14, eysq_s14;
	logic [34:0]        rsum_s15;
	logic signed [18:0] ep, em;
	logic signed [35:0] exsq_full, eysq_full;

	assign ep        = dpc_s11[18] ? -dpc_s11 : dpc_s11;
	assign em        = dmc_s11[18] ? -dmc_s11 : dmc_s11;
	assign exsq_full = ex_s13 * ex_s13;
	assign eysq_full = ey_s13 * ey_s13;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
			v_s15 <= 1'b0;
		end else if (en) begin
			v_s11 <= dmv;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
			v_s15 <= v_s14;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dpc_s11 <= $signed({2'b00, dmsb_out.dp}) - $signed({3'b000, dmsb_out.c});
			dmc_s11 <= $signed({1'b0, dm_root}) - $signed({3'b000, dmsb_out.c});
			msb_s11 <= dmsb_out;

			y_s12   <= ($unsigned(ep) < $unsigned(em)) ? $signed({1'b0, msb_s11.h})
				: -$signed({1'b0, msb_s11.h});
			x_s12   <= msb_s11.x;
			bad_s12 <= msb_s11.bad;
			rx_s12  <= msb_s11.rx;
			ry_s12  <= msb_s11.ry;

			ex_s13  <= {x_s12[16], x_s12} - {{2{rx_s12[15]}}, rx_s12};
			ey_s13  <= {y_s12[16], y_s12} - {{2{ry_s12[15]}}, ry_s12};
			x_s13   <= x_s12;
			y_s13   <= y_s12;
			bad_s13 <= bad_s12;

			exsq_s14 <= exsq_full[33:0];
			eysq_s14 <= eysq_full[33:0];
			x_s14    <= x_s13;
			y_s14    <= y_s13;
			bad_s14  <= bad_s13;

			rsum_s15 <= {1'b0, exsq_s14} + {1'b0, eysq_s14};
			x_s15    <= x_s14;
			y_s15    <= y_s14;
			bad_s15  <= bad_s14;
		end
	end

	r_sb_t rsb_in, rsb_out;
	logic  rv;
	logic [17:0] r_root;

	assign rsb_in.bad = bad_s15;
	assign rsb_in.x   = x_s15;
	assign rsb_in.y   = y_s15;

	tapf_sqrt_chain #(.RW(18), .SBW($bits(r_sb_t))) u_ref (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_i    (v_s15),
		.rad_i  ({1'b0, rsum_s15}),
		.sb_i   (rsb_in),
		.v_o    (rv),
		.root_o (r_root),
		.sb_o   (rsb_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= rv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			solved       <= !rsb_out.bad;
			pos_x        <= rsb_out.bad ? '0 : rsb_out.x;
			pos_y        <= rsb_out.bad ? '0 : rsb_out.y;
			ref_distance <= rsb_out.bad ? '0 : r_root;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !solved |-> pos_x == '0 && pos_y == '0 && ref_distance == '0)
		else $error("unsolved word carries nonzero fields");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall out of step with output");

	assert property (@(posedge clk) disable iff (!arst_n)
		dv[NQ] && !dq_sb.bad |-> drem[NQ] < tapf_pkg::REM_W'(dd[NQ]))
		else $error("divider remainder not below divisor");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> v_s1)
		else $error("accepted word lost at chain entry");

endmodule
